// ===== rtl/gda_pkg.sv =====
// gda_pkg: shared types, codes and calendar constants of the gregorian date adder
// no dependencies; imported by the datapath, the controller and the top level
`timescale 1ns / 1ps

package gda_pkg;

    typedef enum logic [1:0] {
        FUNC_DAYS   = 2'd0,
        FUNC_MONTHS = 2'd1,
        FUNC_YEARS  = 2'd2,
        FUNC_NONE   = 2'd3
    } gda_func_t;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;
    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
    localparam logic [4:0] FEB_PLAIN_LEN = 5'd28;
    // 400 = 16 * 25 and 100 = 4 * 25, so the leap rule needs only the year mod 25
    localparam logic [5:0] RES_MOD = 6'd25;
    localparam logic [4:0] RES_LAST = 5'd24;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // month is always 1..12 here
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic is_leap);
        logic [3:0] idx;
        idx = m - 4'd1;
        if (m == MON_FEB)
            days_in = is_leap ? FEB_LEAP_LEN : FEB_PLAIN_LEN;
        else
            days_in = MONTH_LEN[idx];
    endfunction

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [15:0] amount;
    } gda_req_t;

    typedef struct packed {
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [15:0] new_year;
    } gda_rsp_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic res_bit;
        logic clamp;
        logic step_day;
        logic step_month;
        logic add_year;
        logic out_load;
    } gda_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        gda_func_t func;
        logic      amt_zero;
        logic      res_done;
    } gda_stat_t;

endpackage

// ===== rtl/gda_req_if.sv =====
// gda_req_if: request channel of the date adder, valid/ready plus start date word
// no dependencies
`timescale 1ns / 1ps

interface gda_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] amount;

    modport source (output valid, output func, output day, output month,
                    output year, output amount, input ready);
    modport sink (input valid, input func, input day, input month,
                  input year, input amount, output ready);
endinterface

// ===== rtl/gda_rsp_if.sv =====
// gda_rsp_if: result channel of the date adder, valid/ready plus resulting date word
// no dependencies
`timescale 1ns / 1ps

interface gda_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;

    modport source (output valid, output new_day, output new_month,
                    output new_year, input ready);
    modport sink (input valid, input new_day, input new_month,
                  input new_year, output ready);
endinterface

// ===== rtl/gda_datapath.sv =====
// gda_datapath: date registers, step counter, reciprocal year mod 25 unit, result register
// depends on gda_pkg
`timescale 1ns / 1ps

module gda_datapath
    import gda_pkg::*;
#(
    parameter int YEAR_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  gda_cmd_t  cmd,
    input  gda_req_t  req_word,
    output gda_stat_t stat,
    output gda_rsp_t  rsp_word
);

    localparam int RECIP_SHIFT = YEAR_BITS + 5;
    // ceil(2^RECIP_SHIFT / 25), gives the exact quotient for every year of YEAR_BITS bits
    localparam logic [YEAR_BITS:0] RECIP =
        (YEAR_BITS+1)'(((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25);

    gda_func_t            func_reg, func_next;
    logic [4:0]           day_reg, day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [15:0]          cnt_reg, cnt_next;
    logic [4:0]           res_reg, res_next;
    logic [4:0]           quo_reg, quo_next;
    logic                 res_ph_reg, res_ph_next;
    gda_rsp_t             out_reg, out_next;

    logic                 leap_cur;
    logic [4:0]           len_cur;
    logic                 yr_wrap;
    logic [3:0]           month_roll;
    logic [YEAR_BITS-1:0] year_inc;
    logic [4:0]           res_inc;
    logic [YEAR_BITS-1:0] year_m;
    logic [4:0]           res_m;
    logic                 leap_m;
    logic [4:0]           len_m;
    logic [2*YEAR_BITS:0] quo_prod;
    logic [4:0]           res_calc;
    logic [4:0]           day_in;
    logic [3:0]           month_in;

    // leap: divisible by 4, and either not by 25 or also by 16
    assign leap_cur = (year_reg[1:0] == 2'd0) && ((res_reg != 5'd0) || (year_reg[3:0] == 4'd0));
    assign len_cur  = days_in(month_reg, leap_cur);

    assign yr_wrap    = (month_reg == MON_DEC);
    assign month_roll = yr_wrap ? MON_JAN : month_reg + 4'd1;
    assign year_inc   = year_reg + YEAR_BITS'(1);
    // wrap of the year to zero restarts the residue
    assign res_inc    = ((year_reg == '1) || (res_reg == RES_LAST)) ? 5'd0 : res_reg + 5'd1;

    assign year_m = yr_wrap ? year_inc : year_reg;
    assign res_m  = yr_wrap ? res_inc : res_reg;
    assign leap_m = (year_m[1:0] == 2'd0) && ((res_m != 5'd0) || (year_m[3:0] == 4'd0));
    assign len_m  = days_in(month_roll, leap_m);

    // first pass: quotient by reciprocal multiply; second pass: residue
    assign quo_prod = {{(YEAR_BITS+1){1'b0}}, year_reg} * {{YEAR_BITS{1'b0}}, RECIP};
    // residue is below 32, so five low bits of quotient and year suffice
    assign res_calc = year_reg[4:0] - (quo_reg * 5'd25);

    assign day_in   = (req_word.day == 5'd0) ? DAY_FIRST : req_word.day;
    assign month_in = (req_word.month == 4'd0) ? MON_JAN :
                      (req_word.month > MON_DEC) ? MON_DEC : req_word.month;

    always_comb
    begin
        func_next   = func_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        quo_next    = quo_reg;
        res_ph_next = res_ph_reg;
        out_next    = out_reg;
        if (cmd.load)
        begin
            func_next   = gda_func_t'(req_word.func);
            day_next    = day_in;
            month_next  = month_in;
            year_next   = YEAR_BITS'(req_word.year);
            cnt_next    = req_word.amount;
            res_next    = 5'd0;
            res_ph_next = 1'b0;
        end
        if (cmd.res_bit)
        begin
            if (!res_ph_reg)
            begin
                quo_next    = quo_prod[RECIP_SHIFT +: 5];
                res_ph_next = 1'b1;
            end
            else
            begin
                res_next = res_calc;
            end
        end
        if (cmd.clamp)
        begin
            if (day_reg > len_cur)
                day_next = len_cur;
        end
        if (cmd.step_day)
        begin
            cnt_next = cnt_reg - 16'd1;
            if (day_reg == len_cur)
            begin
                day_next   = DAY_FIRST;
                month_next = month_roll;
                year_next  = year_m;
                res_next   = res_m;
            end
            else
            begin
                day_next = day_reg + 5'd1;
            end
        end
        if (cmd.step_month)
        begin
            cnt_next   = cnt_reg - 16'd1;
            month_next = month_roll;
            year_next  = year_m;
            res_next   = res_m;
            if (day_reg > len_m)
                day_next = len_m;
        end
        if (cmd.add_year)
        begin
            year_next   = year_reg + YEAR_BITS'(cnt_reg);
            res_next    = 5'd0;
            res_ph_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_next.new_day   = day_reg;
            out_next.new_month = month_reg;
            out_next.new_year  = 16'(year_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        day_reg    <= day_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        quo_reg    <= quo_next;
        res_ph_reg <= res_ph_next;
        out_reg    <= out_next;
    end

    assign stat.func     = func_reg;
    assign stat.amt_zero = (cnt_reg == 16'd0);
    assign stat.res_done = res_ph_reg;
    assign rsp_word      = out_reg;

    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_bit |=> (res_reg < RES_LAST + 5'd1))
        else $error("year residue left its range");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_day || cmd.step_month) |=> (cnt_reg == $past(cnt_reg) - 16'd1))
        else $error("step counter did not move by one");

    a_clamp_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clamp |=> (day_reg <= len_cur) && (day_reg != 5'd0))
        else $error("day exceeds month length after clamp");

endmodule

// ===== rtl/gda_ctrl.sv =====
// gda_ctrl: one-hot sequencer of the date adder, drives datapath commands and handshakes
// depends on gda_pkg
`timescale 1ns / 1ps

module gda_ctrl
    import gda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  gda_stat_t stat,
    output gda_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RES   = 8'b0000_0010,
        S_CLAMP = 8'b0000_0100,
        S_STEP  = 8'b0000_1000,
        S_ADDY  = 8'b0001_0000,
        S_RESY  = 8'b0010_0000,
        S_FIX   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } gda_state_t;

    gda_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       out_free;

    assign out_free  = !ovalid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                cmd.res_bit = 1'b1;
                if (stat.res_done)
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp = 1'b1;
                unique case (stat.func) inside
                    FUNC_DAYS, FUNC_MONTHS: state_next = S_STEP;
                    FUNC_YEARS:             state_next = S_ADDY;
                    default:                state_next = S_DONE;
                endcase
            end
            S_STEP:
            begin
                if (stat.amt_zero)
                    state_next = S_DONE;
                else if (stat.func == FUNC_DAYS)
                    cmd.step_day = 1'b1;
                else
                    cmd.step_month = 1'b1;
            end
            S_ADDY:
            begin
                cmd.add_year = 1'b1;
                state_next   = S_RESY;
            end
            S_RESY:
            begin
                cmd.res_bit = 1'b1;
                if (stat.res_done)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.out_load)
            ovalid_next = 1'b1;
        else if (rsp_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!ovalid_reg || rsp_ready))
        else $error("result register overwritten while full");

    a_step_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_day || cmd.step_month) |-> !stat.amt_zero)
        else $error("step issued with no count left");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.out_load)
        else $error("result loaded right after accept");

endmodule

// ===== rtl/gregorian_date_adder.sv =====
// gregorian_date_adder: top level, adds days, months or years to a gregorian date
// depends on gda_pkg, gda_req_if, gda_rsp_if, gda_ctrl, gda_datapath
`timescale 1ns / 1ps
//
// channel  modport  word fields                              direction
// req      sink     func, day, month, year, amount           in
// rsp      source   new_day, new_month, new_year             out
//
// one item at a time; after accept the year mod 25 unit runs its pass (reciprocal
// multiply, then residue) and the start date is clamped; days and months then
// step once per unit of amount (one step per cycle), years add the amount and run
// the residue pass and the clamp again, and the unused selector goes to the result
// reset clears only the sequencer and the result valid flag
// a waiting result does not block the next item; only a second finished result stalls

module gregorian_date_adder
    import gda_pkg::*;
#(
    parameter int YEAR_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    gda_req_if.sink   req,
    gda_rsp_if.source rsp
);

    gda_cmd_t  cmd;
    gda_stat_t stat;
    gda_req_t  req_word;
    gda_rsp_t  rsp_word;

    // pack the incoming word for the datapath
    assign req_word.func   = req.func;
    assign req_word.day    = req.day;
    assign req_word.month  = req.month;
    assign req_word.year   = req.year;
    assign req_word.amount = req.amount;

    // sequencer: accept, residue passes, clamp, step loop or year add, result hand-off
    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // date registers, year residue unit and result register
    gda_datapath #(
        .YEAR_BITS (YEAR_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_word (req_word),
        .stat     (stat),
        .rsp_word (rsp_word)
    );

    // result word straight from the output register
    assign rsp.new_day   = rsp_word.new_day;
    assign rsp.new_month = rsp_word.new_month;
    assign rsp.new_year  = rsp_word.new_year;

endmodule

// ===== tb/tb_gregorian_date_adder.sv =====
// tb_gregorian_date_adder: self-checking testbench of the gregorian date adder
// depends on gda_pkg, gda_req_if, gda_rsp_if and the gregorian_date_adder rtl
`timescale 1ns / 1ps

module tb_gregorian_date_adder
    import gda_pkg::*;
();

    // directed rows first, then random words
    localparam int NUM_DIRECTED = 24;
    localparam int RANDOM_ITEMS = 76;
    // quiet period after the last result
    localparam int DRAIN_CYCLES = 40;
    // years that sit on the leap rule or on the wrap
    localparam logic [15:0] CORNER_YEARS [7] = '{
        16'd0, 16'd65535, 16'd65532, 16'd1900, 16'd2000, 16'd2100, 16'd2400
    };

    // one directed row; typed rows carry their own expected date
    typedef struct {
        gda_func_t   func;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [15:0] amount;
        bit          typed;
        logic [4:0]  exp_day;
        logic [3:0]  exp_month;
        logic [15:0] exp_year;
    } date_case_t;

    date_case_t directed_cases [NUM_DIRECTED] = '{
        // unused selector: start date comes back corrected
        '{FUNC_NONE,   5'd0,  4'd0,  16'd2024,  16'd5,     1'b1, 5'd1,  4'd1,  16'd2024},
        '{FUNC_NONE,   5'd31, 4'd15, 16'd100,   16'd0,     1'b1, 5'd31, 4'd12, 16'd100},
        '{FUNC_NONE,   5'd31, 4'd2,  16'd1900,  16'd9,     1'b1, 5'd28, 4'd2,  16'd1900},
        '{FUNC_NONE,   5'd30, 4'd2,  16'd2000,  16'd0,     1'b1, 5'd29, 4'd2,  16'd2000},
        // days: year wrap, end of february, zero amount
        '{FUNC_DAYS,   5'd31, 4'd12, 16'd65535, 16'd1,     1'b1, 5'd1,  4'd1,  16'd0},
        '{FUNC_DAYS,   5'd28, 4'd2,  16'd2023,  16'd1,     1'b1, 5'd1,  4'd3,  16'd2023},
        '{FUNC_DAYS,   5'd28, 4'd2,  16'd2024,  16'd1,     1'b1, 5'd29, 4'd2,  16'd2024},
        '{FUNC_DAYS,   5'd15, 4'd6,  16'd1234,  16'd0,     1'b1, 5'd15, 4'd6,  16'd1234},
        '{FUNC_DAYS,   5'd1,  4'd1,  16'd2000,  16'd366,   1'b0, 5'd0,  4'd0,  16'd0},
        '{FUNC_DAYS,   5'd31, 4'd12, 16'd65535, 16'd65535, 1'b0, 5'd0,  4'd0,  16'd0},
        // months: clamp and its carry into later steps
        '{FUNC_MONTHS, 5'd31, 4'd1,  16'd2023,  16'd1,     1'b1, 5'd28, 4'd2,  16'd2023},
        '{FUNC_MONTHS, 5'd31, 4'd1,  16'd2024,  16'd2,     1'b0, 5'd0,  4'd0,  16'd0},
        '{FUNC_MONTHS, 5'd15, 4'd12, 16'd65535, 16'd1,     1'b1, 5'd15, 4'd1,  16'd0},
        '{FUNC_MONTHS, 5'd31, 4'd5,  16'd2000,  16'd65535, 1'b0, 5'd0,  4'd0,  16'd0},
        // years: leap day into leap and plain years, century rule, wrap
        '{FUNC_YEARS,  5'd29, 4'd2,  16'd2024,  16'd1,     1'b1, 5'd28, 4'd2,  16'd2025},
        '{FUNC_YEARS,  5'd29, 4'd2,  16'd2024,  16'd4,     1'b1, 5'd29, 4'd2,  16'd2028},
        '{FUNC_YEARS,  5'd29, 4'd2,  16'd1996,  16'd4,     1'b1, 5'd29, 4'd2,  16'd2000},
        '{FUNC_YEARS,  5'd29, 4'd2,  16'd2096,  16'd4,     1'b1, 5'd28, 4'd2,  16'd2100},
        '{FUNC_YEARS,  5'd10, 4'd7,  16'd65535, 16'd65535, 1'b1, 5'd10, 4'd7,  16'd65534},
        '{FUNC_YEARS,  5'd29, 4'd2,  16'd0,     16'd65535, 1'b1, 5'd28, 4'd2,  16'd65535},
        // out-of-range day and month under stepping and under a year add; a leap day step
        '{FUNC_DAYS,   5'd0,  4'd13, 16'd7,     16'd40,    1'b0, 5'd0,  4'd0,  16'd0},
        '{FUNC_MONTHS, 5'd31, 4'd0,  16'd99,    16'd25,    1'b0, 5'd0,  4'd0,  16'd0},
        '{FUNC_YEARS,  5'd31, 4'd4,  16'd1600,  16'd400,   1'b1, 5'd30, 4'd4,  16'd2000},
        '{FUNC_DAYS,   5'd29, 4'd2,  16'd1600,  16'd1,     1'b1, 5'd1,  4'd3,  16'd1600}
    };

    logic clk;
    logic rst_n;

    gda_req_if req_ch ();
    gda_rsp_if rsp_ch ();

    gregorian_date_adder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // dates still owed by the block, oldest first
    gda_rsp_t pending_dates [$];
    int       mismatches = 0;
    // when set, the request side sends back to back
    bit       req_quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // leap rule on the wrapped 16-bit year
    function automatic bit leap_year(input logic [15:0] y);
        int yi;
        yi = int'(y);
        return (yi % 400 == 0) || (yi % 4 == 0 && yi % 100 != 0);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
        case (m)
            MON_FEB:                 return leap_year(y) ? FEB_LEAP_LEN : FEB_PLAIN_LEN;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return 5'd31;
        endcase
    endfunction

    // date that the block should return for one request word
    function automatic gda_rsp_t advance_date(input gda_req_t w);
        logic [4:0]  d;
        logic [3:0]  m;
        logic [15:0] y;
        int          i;
        gda_rsp_t    r;
        d = w.day;
        m = w.month;
        y = w.year;
        // bring the start date into range first
        if (m < MON_JAN)
            m = MON_JAN;
        if (m > MON_DEC)
            m = MON_DEC;
        if (d < DAY_FIRST)
            d = DAY_FIRST;
        if (d > month_length(m, y))
            d = month_length(m, y);
        case (gda_func_t'(w.func))
            FUNC_DAYS:
            begin
                for (i = 0; i < int'(w.amount); i++)
                begin
                    if (d == month_length(m, y))
                    begin
                        d = DAY_FIRST;
                        if (m == MON_DEC)
                        begin
                            m = MON_JAN;
                            y = y + 16'd1;
                        end
                        else
                            m = m + 4'd1;
                    end
                    else
                        d = d + 5'd1;
                end
            end
            FUNC_MONTHS:
            begin
                // the clamp stays in d, so it carries into later months
                for (i = 0; i < int'(w.amount); i++)
                begin
                    if (m == MON_DEC)
                    begin
                        m = MON_JAN;
                        y = y + 16'd1;
                    end
                    else
                        m = m + 4'd1;
                    if (d > month_length(m, y))
                        d = month_length(m, y);
                end
            end
            FUNC_YEARS:
            begin
                y = y + w.amount;
                if (m == MON_FEB && d == FEB_LEAP_LEN && !leap_year(y))
                    d = FEB_PLAIN_LEN;
            end
            default:
            begin
            end
        endcase
        r.new_day   = d;
        r.new_month = m;
        r.new_year  = y;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // drive one request word after a random gap and wait for the handshake;
    // the expected date is queued at the accepting edge
    task automatic send_date(input gda_req_t w, input gda_rsp_t expected);
        int gap;
        gap = req_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.func   <= w.func;
        req_ch.day    <= w.day;
        req_ch.month  <= w.month;
        req_ch.year   <= w.year;
        req_ch.amount <= w.amount;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_dates.push_back(expected);
    endtask

    // request side: reset, directed table, random words, drain, verdict
    initial
    begin
        gda_req_t   w;
        gda_rsp_t   e;
        logic [4:0] len;
        int         k;
        int         pick;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.func   <= FUNC_DAYS;
        req_ch.day    <= 5'd0;
        req_ch.month  <= 4'd0;
        req_ch.year   <= 16'd0;
        req_ch.amount <= 16'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; typed rows use their own date, the rest the predictor
        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            w.func   = directed_cases[k].func;
            w.day    = directed_cases[k].day;
            w.month  = directed_cases[k].month;
            w.year   = directed_cases[k].year;
            w.amount = directed_cases[k].amount;
            if (directed_cases[k].typed)
            begin
                e.new_day   = directed_cases[k].exp_day;
                e.new_month = directed_cases[k].exp_month;
                e.new_year  = directed_cases[k].exp_year;
            end
            else
                e = advance_date(w);
            send_date(w, e);
        end

        // random words: mostly valid dates, some raw noise on func/day/month
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            // every third block of 16 words goes back to back
            req_quiet = ((k / 16) % 3 == 1);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                w.func = FUNC_DAYS;
            else if (pick < 75)
                w.func = FUNC_MONTHS;
            else if (pick < 95)
                w.func = FUNC_YEARS;
            else
                w.func = FUNC_NONE;
            if ($urandom_range(0, 3) == 0)
                w.year = CORNER_YEARS[3'($urandom_range(0, 6))];
            else
                w.year = 16'($urandom_range(0, 65535));
            w.month = 4'($urandom_range(1, 12));
            len = month_length(w.month, w.year);
            // lean on month ends, where the rollover and clamp logic lives
            if ($urandom_range(0, 3) == 0)
                w.day = len;
            else
                w.day = 5'($urandom_range(1, len));
            if ($urandom_range(0, 99) < 15)
            begin
                w.func  = 2'($urandom_range(0, 3));
                w.day   = 5'($urandom_range(0, 31));
                w.month = 4'($urandom_range(0, 15));
            end
            // stepping modes take one step per unit of amount, so only a couple go long
            if (w.func == FUNC_YEARS || w.func == FUNC_NONE || k % 40 == 20)
                w.amount = 16'($urandom_range(0, 65535));
            else if ($urandom_range(0, 9) < 6)
                w.amount = 16'($urandom_range(0, 40));
            else if (w.func == FUNC_DAYS)
                w.amount = 16'($urandom_range(0, 1500));
            else
                w.amount = 16'($urandom_range(0, 600));
            send_date(w, advance_date(w));
        end
        req_ch.valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random stall, then take one word and check it
    initial
    begin
        int       stall;
        int       taken;
        gda_rsp_t e;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // every third block of 12 results is taken without stalling
            stall = ((taken / 12) % 3 == 2) ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            taken++;
            if (pending_dates.size() == 0)
                report_mismatch($sformatf("unexpected date %0d/%0d/%0d",
                    rsp_ch.new_day, rsp_ch.new_month, rsp_ch.new_year));
            else
            begin
                e = pending_dates.pop_front();
                if (rsp_ch.new_day !== e.new_day)
                    report_mismatch($sformatf("new_day got %0d want %0d",
                        rsp_ch.new_day, e.new_day));
                if (rsp_ch.new_month !== e.new_month)
                    report_mismatch($sformatf("new_month got %0d want %0d",
                        rsp_ch.new_month, e.new_month));
                if (rsp_ch.new_year !== e.new_year)
                    report_mismatch($sformatf("new_year got %0d want %0d",
                        rsp_ch.new_year, e.new_year));
            end
        end
    end

    // watchdog, several times the slowest legal run of this stimulus
    initial
    begin
        #25_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
